### hw/rtl/fpes_pkg.sv
`default_nettype none

package fpes_pkg;

    // Width of the latched flash address (at most 32)
    localparam int ADDR_WIDTH = 32;

    localparam int TMO_WIDTH = 20;

    localparam logic [TMO_WIDTH-1:0] ERASE_TMO_RST = 20'h B0000;
    localparam logic [TMO_WIDTH-1:0] PROG_TMO_RST  = 20'h 02000;

    localparam logic [31:0] KEY_FIRST  = 32'h 4567_0123;
    localparam logic [31:0] KEY_SECOND = 32'h CDEF_89AB;
    localparam logic [31:0] BIT_PG     = 32'h 0000_0001;
    localparam logic [31:0] BIT_PER    = 32'h 0000_0002;
    localparam logic [31:0] BIT_OPTPG  = 32'h 0000_0010;
    localparam logic [31:0] BIT_OPTER  = 32'h 0000_0020;
    localparam logic [31:0] BIT_START  = 32'h 0000_0040;

    typedef enum logic [1:0] {
        ACT_TICK   = 2'd0,
        ACT_START  = 2'd1,
        ACT_CANCEL = 2'd2,
        ACT_CLEAR  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        OP_PAGE_ERASE = 2'd0,
        OP_WORD_PROG  = 2'd1,
        OP_OPT_ERASE  = 2'd2,
        OP_OPT_PROG   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        STAT_BUSY = 2'd0,
        STAT_DONE = 2'd1
    } t_status;

    typedef enum logic [3:0] {
        ST_IDLE      = 4'd0,
        ST_INIT      = 4'd1,
        ST_UNLOCK    = 4'd2,
        ST_CLEARFLAG = 4'd3,
        ST_WAITREADY = 4'd4,
        ST_SETOP     = 4'd5,
        ST_SETADDR   = 4'd6,
        ST_START     = 4'd7,
        ST_WAITDONE  = 4'd8,
        ST_LOCK      = 4'd9,
        ST_DONE      = 4'd10,
        ST_ERROR     = 4'd11
    } t_seq_state;

    typedef enum logic [1:0] {
        RES_SUCCESS = 2'd0,
        RES_PENDING = 2'd1,
        RES_ERROR   = 2'd2,
        RES_TIMEOUT = 2'd3
    } t_result;

    typedef enum logic [3:0] {
        CMD_NONE       = 4'd0,
        CMD_UNLOCK     = 4'd1,
        CMD_UNLOCK_OPT = 4'd2,
        CMD_CLR_FLAGS  = 4'd3,
        CMD_SET_CTRL   = 4'd4,
        CMD_WR_ADDR    = 4'd5,
        CMD_WR_WORD    = 4'd6,
        CMD_SET_START  = 4'd7,
        CMD_CLR_LOCK   = 4'd8,
        CMD_LOCK       = 4'd9
    } t_cmd_kind;

    typedef enum logic {
        CFG_ERASE_TMO = 1'b0,
        CFG_PROG_TMO  = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic [1:0]  action;
        logic [2:0]  op_type;
        logic [31:0] target_address;
        logic [31:0] word_data;
        logic [15:0] opt_value;
        logic [1:0]  flash_status;
    } t_in_item;

    typedef struct packed {
        logic        accepted;
        logic [3:0]  seq_state;
        logic [1:0]  result_code;
        logic        result_event;
        logic [3:0]  cmd_kind;
        logic [31:0] cmd_address;
        logic [31:0] cmd_value;
    } t_out_item;

    // Sequencer context carried from one event to the next
    typedef struct packed {
        t_seq_state             state;
        t_result                result;
        logic [TMO_WIDTH-1:0]   ticks_left;
        t_op                    op;
        logic [ADDR_WIDTH-1:0]  addr;
        logic [31:0]            word;
        logic [15:0]            option;
    } t_ctx;

    typedef struct packed {
        logic [TMO_WIDTH-1:0] erase_tmo;
        logic [TMO_WIDTH-1:0] prog_tmo;
    } t_cfg;

    function automatic logic [31:0] mode_bit(input t_op op);
        logic [31:0] m;
        case (op)
            OP_PAGE_ERASE: m = BIT_PER;
            OP_WORD_PROG:  m = BIT_PG;
            OP_OPT_ERASE:  m = BIT_OPTER;
            OP_OPT_PROG:   m = BIT_OPTPG;
            default:       m = BIT_PER;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/fpes_step.sv
`default_nettype none

// One event applied to the sequencer context; pure combinational.
module fpes_step
    import fpes_pkg::*;
(
    input  wire t_ctx      i_ctx,
    input  wire t_in_item  i_item,
    input  wire t_cfg      i_cfg,
    output t_ctx           o_ctx,
    output t_out_item      o_result
);

    t_ctx        n_ctx;
    logic        accepted;
    logic        evt;
    t_cmd_kind   kind;
    logic [31:0] caddr;
    logic [31:0] cval;
    logic        active;
    t_seq_state  wait_next;
    logic [31:0] addr_ext;

    assign active    = (i_ctx.state != ST_IDLE) && (i_ctx.state != ST_DONE) &&
                       (i_ctx.state != ST_ERROR);
    assign wait_next = (i_ctx.state == ST_WAITREADY) ? ST_SETOP : ST_LOCK;
    assign addr_ext  = 32'(i_ctx.addr);

    always_comb begin
        n_ctx    = i_ctx;
        accepted = 1'b0;
        evt      = 1'b0;
        kind     = CMD_NONE;
        caddr    = '0;
        cval     = '0;

        case (t_action'(i_item.action))
            ACT_START: begin
                if (i_ctx.state == ST_IDLE) begin
                    n_ctx.op     = t_op'(i_item.op_type[1:0]);
                    n_ctx.addr   = i_item.target_address[ADDR_WIDTH-1:0];
                    n_ctx.word   = i_item.word_data;
                    n_ctx.option = i_item.opt_value;
                    n_ctx.result = RES_PENDING;
                    // invalid type: latched and pending, but stays idle
                    if (!i_item.op_type[2]) begin
                        n_ctx.ticks_left = i_item.op_type[0] ? i_cfg.prog_tmo
                                                             : i_cfg.erase_tmo;
                        n_ctx.state      = ST_INIT;
                        accepted         = 1'b1;
                    end
                end
            end
            ACT_CANCEL: begin
                if (active) begin
                    kind         = CMD_LOCK;
                    n_ctx.result = RES_ERROR;
                    n_ctx.state  = ST_ERROR;
                    evt          = 1'b1;
                end
            end
            ACT_CLEAR: begin
                n_ctx.state      = ST_IDLE;
                n_ctx.result     = RES_SUCCESS;
                n_ctx.ticks_left = '0;
            end
            ACT_TICK: begin
                case (i_ctx.state)
                    ST_INIT: begin
                        n_ctx.state = ST_UNLOCK;
                    end
                    ST_UNLOCK: begin
                        kind = i_ctx.op[1] ? CMD_UNLOCK_OPT : CMD_UNLOCK;
                        caddr       = KEY_FIRST;
                        cval        = KEY_SECOND;
                        n_ctx.state = ST_CLEARFLAG;
                    end
                    ST_CLEARFLAG: begin
                        kind        = CMD_CLR_FLAGS;
                        n_ctx.state = ST_WAITREADY;
                    end
                    ST_WAITREADY, ST_WAITDONE: begin
                        case (t_status'(i_item.flash_status))
                            STAT_BUSY: begin
                                if (i_ctx.ticks_left == '0) begin
                                    n_ctx.result = RES_TIMEOUT;
                                    n_ctx.state  = ST_ERROR;
                                    evt          = 1'b1;
                                end else begin
                                    n_ctx.ticks_left = i_ctx.ticks_left - 1'b1;
                                end
                            end
                            STAT_DONE: begin
                                n_ctx.state = wait_next;
                            end
                            default: begin
                                n_ctx.result = RES_ERROR;
                                n_ctx.state  = ST_ERROR;
                                evt          = 1'b1;
                            end
                        endcase
                    end
                    ST_SETOP: begin
                        kind        = CMD_SET_CTRL;
                        cval        = mode_bit(i_ctx.op);
                        n_ctx.state = (i_ctx.op == OP_OPT_ERASE) ? ST_START : ST_SETADDR;
                    end
                    ST_SETADDR: begin
                        case (i_ctx.op)
                            OP_PAGE_ERASE: begin
                                kind        = CMD_WR_ADDR;
                                caddr       = addr_ext;
                                cval        = addr_ext;
                                n_ctx.state = ST_START;
                            end
                            OP_WORD_PROG: begin
                                kind        = CMD_WR_WORD;
                                caddr       = addr_ext;
                                cval        = i_ctx.word;
                                n_ctx.state = ST_START;
                            end
                            OP_OPT_PROG: begin
                                kind        = CMD_WR_WORD;
                                caddr       = addr_ext;
                                cval        = {8'h00, i_ctx.option[15:8],
                                               8'h00, i_ctx.option[7:0]};
                                n_ctx.state = ST_START;
                            end
                            default: ;  // option erase never gets here; hold
                        endcase
                    end
                    ST_START: begin
                        kind        = CMD_SET_START;
                        cval        = BIT_START;
                        n_ctx.state = ST_WAITDONE;
                    end
                    ST_LOCK: begin
                        kind         = CMD_CLR_LOCK;
                        cval         = mode_bit(i_ctx.op);
                        n_ctx.result = RES_SUCCESS;
                        n_ctx.state  = ST_DONE;
                        evt          = 1'b1;
                    end
                    default: ;  // idle, done, error: tick does nothing
                endcase
            end
            default: ;
        endcase
    end

    assign o_ctx                 = n_ctx;
    assign o_result.accepted     = accepted;
    assign o_result.seq_state    = n_ctx.state;
    assign o_result.result_code  = n_ctx.result;
    assign o_result.result_event = evt;
    assign o_result.cmd_kind     = kind;
    assign o_result.cmd_address  = caddr;
    assign o_result.cmd_value    = cval;

endmodule

`default_nettype wire

### hw/rtl/flash_program_erase_sequencer_top.sv
// A taken transfer goes into the event register, then its result into the result register and o_result.
// Throughput: one event per cycle unless the receiver stalls; the event register feeds the
//   step logic, whose result lands in the output register while the sequencer context updates.
// Reset (i_rst_n low, synchronous): state idle, result success, countdown and latches
//   zero, both timeouts back to their defaults, both pipeline stages empty.
`default_nettype none

module flash_program_erase_sequencer_top
    import fpes_pkg::*;
(
    input  wire                 i_clk,
    input  wire                 i_rst_n,

    // event channel
    input  wire                 i_valid,
    output logic                o_stall,
    input  wire t_in_item       i_item,

    // result channel
    output logic                o_valid,
    input  wire                 i_stall,
    output t_out_item           o_result,

    // timeout register writes
    input  wire                 i_cfg_we,
    input  wire                 i_cfg_idx,
    input  wire [TMO_WIDTH-1:0] i_cfg_data
);

    // event register
    logic       r_in_vld;
    t_in_item   r_in;
    // result register
    logic       r_out_vld;
    t_out_item  r_out;
    // sequencer context and timeouts
    t_ctx       r_ctx;
    t_ctx       n_ctx;
    t_cfg       r_cfg;
    t_out_item  n_out;

    logic       out_load;   // event register moves into the result register
    logic       in_take;    // new transfer into the event register

    // The result register takes a new item when empty or when its item leaves.
    assign out_load = r_in_vld && (!r_out_vld || !i_stall);
    assign o_stall  = r_in_vld && !out_load;
    assign in_take  = i_valid && !o_stall;

    fpes_step u_step (
        .i_ctx    (r_ctx),
        .i_item   (r_in),
        .i_cfg    (r_cfg),
        .o_ctx    (n_ctx),
        .o_result (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_take) begin
            r_in_vld <= 1'b1;
        end else if (out_load) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_load) begin
            r_out_vld <= 1'b1;
        end else if (!i_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= n_out;
        end
    end

    // Context moves exactly once per event, in step with the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctx.state      <= ST_IDLE;
            r_ctx.result     <= RES_SUCCESS;
            r_ctx.ticks_left <= '0;
            r_ctx.op         <= OP_PAGE_ERASE;
            r_ctx.addr       <= '0;
            r_ctx.word       <= '0;
            r_ctx.option     <= '0;
        end else if (out_load) begin
            r_ctx <= n_ctx;
        end
    end

    // Writes must arrive only while no transfer is in flight; the block itself does not enforce this.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.erase_tmo <= ERASE_TMO_RST;
            r_cfg.prog_tmo  <= PROG_TMO_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_ERASE_TMO: r_cfg.erase_tmo <= i_cfg_data;
                CFG_PROG_TMO:  r_cfg.prog_tmo  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_valid  = r_out_vld;
    assign o_result = r_out;

    // A final result is only reported on entry to done or error.
    a_event_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.result_event) |->
            (o_result.seq_state == ST_DONE || o_result.seq_state == ST_ERROR))
        else $error("result event outside done/error");

    // A taken start leaves the sequencer in init, pending, with no command.
    a_accept_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.accepted) |->
            (o_result.seq_state == ST_INIT && o_result.result_code == RES_PENDING &&
             o_result.cmd_kind == CMD_NONE))
        else $error("start accepted without entering init");

    // Context and result register advance together.
    a_ctx_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(out_load) |-> $stable(r_ctx))
        else $error("context changed without an event");

endmodule

`default_nettype wire

### dv/flash_program_erase_sequencer_top_tb.sv
`timescale 1ns / 100ps

module flash_program_erase_sequencer_top_tb;
    import fpes_pkg::*;

    // Abort the run long after the slowest legal schedule would have finished.
    localparam int CYCLE_LIMIT = 300000;

    // Flash status codes with no name in the package: anything past "done" is a fault.
    localparam logic [1:0] STAT_FAULT    = 2'd2;
    localparam logic [1:0] STAT_FAULT_HI = 2'd3;

    // Clock, reset and every block input, all known from time zero.
    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 i_valid    = 1'b0;
    t_in_item             i_item     = '0;
    logic                 i_stall    = 1'b0;
    logic                 i_cfg_we   = 1'b0;
    logic                 i_cfg_idx  = 1'b0;
    logic [TMO_WIDTH-1:0] i_cfg_data = '0;

    logic                 o_stall;
    logic                 o_valid;
    t_out_item            o_result;

    flash_program_erase_sequencer_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_item     (i_item),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Events waiting to be driven; hold makes the driver wait until every
    // outstanding result has come back before presenting that event.
    typedef struct {
        t_in_item ev;
        bit       hold;
    } t_pending;

    t_pending   event_q[$];
    t_out_item  expected_steps[$];
    int         queued_total = 0;
    int         err_count    = 0;
    int         cycle_count  = 0;
    int         idle_pct     = 0;
    int         stall_pct    = 0;
    bit         ev_fired     = 1'b0;

    // Sequencer shadow: timeouts and the context carried between events.
    logic [TMO_WIDTH-1:0] erase_tmo = ERASE_TMO_RST;
    logic [TMO_WIDTH-1:0] prog_tmo  = PROG_TMO_RST;
    t_seq_state           seq_st    = ST_IDLE;
    t_result              seq_res   = RES_SUCCESS;
    logic [TMO_WIDTH-1:0] ticks     = '0;
    t_op                  lat_op    = OP_PAGE_ERASE;
    logic [31:0]          lat_addr  = '0;
    logic [31:0]          lat_word  = '0;
    logic [15:0]          lat_opt   = '0;

    // Advance the shadow by one event and return the step it must report.
    function automatic t_out_item step_sequencer(input t_in_item ev);
        t_out_item   r;
        t_op         opl;
        logic [31:0] mbit;
        logic        busy_now;
        t_seq_state  nxt;
        r = '0;
        opl = lat_op;
        busy_now = (seq_st != ST_IDLE) && (seq_st != ST_DONE) && (seq_st != ST_ERROR);
        case (opl)
            OP_PAGE_ERASE: mbit = BIT_PER;
            OP_WORD_PROG:  mbit = BIT_PG;
            OP_OPT_ERASE:  mbit = BIT_OPTER;
            default:       mbit = BIT_OPTPG;
        endcase
        case (ev.action)
            ACT_START: begin
                // Latched even for a bad type; only a good type leaves idle.
                if (seq_st == ST_IDLE) begin
                    lat_op   = t_op'(ev.op_type[1:0]);
                    lat_addr = 32'(ev.target_address[ADDR_WIDTH-1:0]);
                    lat_word = ev.word_data;
                    lat_opt  = ev.opt_value;
                    seq_res  = RES_PENDING;
                    if (!ev.op_type[2]) begin
                        ticks      = ev.op_type[0] ? prog_tmo : erase_tmo;
                        seq_st     = ST_INIT;
                        r.accepted = 1'b1;
                    end
                end
            end
            ACT_CANCEL: begin
                if (busy_now) begin
                    r.cmd_kind     = CMD_LOCK;
                    seq_res        = RES_ERROR;
                    seq_st         = ST_ERROR;
                    r.result_event = 1'b1;
                end
            end
            ACT_CLEAR: begin
                seq_st  = ST_IDLE;
                seq_res = RES_SUCCESS;
                ticks   = '0;
            end
            default: begin
                if (busy_now) begin
                    case (seq_st)
                        ST_INIT: seq_st = ST_UNLOCK;
                        ST_UNLOCK: begin
                            r.cmd_kind    = (opl == OP_OPT_ERASE || opl == OP_OPT_PROG) ?
                                            CMD_UNLOCK_OPT : CMD_UNLOCK;
                            r.cmd_address = KEY_FIRST;
                            r.cmd_value   = KEY_SECOND;
                            seq_st        = ST_CLEARFLAG;
                        end
                        ST_CLEARFLAG: begin
                            r.cmd_kind = CMD_CLR_FLAGS;
                            seq_st     = ST_WAITREADY;
                        end
                        ST_WAITREADY, ST_WAITDONE: begin
                            // Both waits burn the same countdown.
                            nxt = (seq_st == ST_WAITREADY) ? ST_SETOP : ST_LOCK;
                            if (ev.flash_status == STAT_BUSY) begin
                                if (ticks == '0) begin
                                    seq_res        = RES_TIMEOUT;
                                    seq_st         = ST_ERROR;
                                    r.result_event = 1'b1;
                                end else begin
                                    ticks = ticks - 1'b1;
                                end
                            end else if (ev.flash_status == STAT_DONE) begin
                                seq_st = nxt;
                            end else begin
                                seq_res        = RES_ERROR;
                                seq_st         = ST_ERROR;
                                r.result_event = 1'b1;
                            end
                        end
                        ST_SETOP: begin
                            r.cmd_kind  = CMD_SET_CTRL;
                            r.cmd_value = mbit;
                            seq_st      = (opl == OP_OPT_ERASE) ? ST_START : ST_SETADDR;
                        end
                        ST_SETADDR: begin
                            // Option erase never gets here; it would just sit.
                            if (opl == OP_PAGE_ERASE) begin
                                r.cmd_kind    = CMD_WR_ADDR;
                                r.cmd_address = lat_addr;
                                r.cmd_value   = lat_addr;
                                seq_st        = ST_START;
                            end else if (opl == OP_WORD_PROG) begin
                                r.cmd_kind    = CMD_WR_WORD;
                                r.cmd_address = lat_addr;
                                r.cmd_value   = lat_word;
                                seq_st        = ST_START;
                            end else if (opl == OP_OPT_PROG) begin
                                r.cmd_kind    = CMD_WR_WORD;
                                r.cmd_address = lat_addr;
                                r.cmd_value   = {8'h00, lat_opt[15:8], 8'h00, lat_opt[7:0]};
                                seq_st        = ST_START;
                            end
                        end
                        ST_START: begin
                            r.cmd_kind  = CMD_SET_START;
                            r.cmd_value = BIT_START;
                            seq_st      = ST_WAITDONE;
                        end
                        ST_LOCK: begin
                            r.cmd_kind     = CMD_CLR_LOCK;
                            r.cmd_value    = mbit;
                            seq_res        = RES_SUCCESS;
                            seq_st         = ST_DONE;
                            r.result_event = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
        endcase
        r.seq_state   = seq_st;
        r.result_code = seq_res;
        return r;
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            err_count++;
        end
    endtask

    // Driver: change inputs on the falling edge. A presented event stays put
    // until the rising edge that takes it.
    always @(negedge i_clk) begin : drive_events
        t_pending nxt;
        bit       go;
        i_stall <= ($urandom_range(99) < stall_pct);
        if (!i_valid || ev_fired) begin
            go = 1'b0;
            if (event_q.size() != 0 && $urandom_range(99) >= idle_pct)
                go = !(event_q[0].hold && expected_steps.size() != 0);
            if (go) begin
                nxt = event_q.pop_front();
                i_item  <= nxt.ev;
                i_valid <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Monitor: score each result transfer, then predict each event transfer.
    always @(posedge i_clk) begin : score_steps
        t_out_item want;
        ev_fired = 1'b0;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (expected_steps.size() == 0) begin
                    $error("result transfer with nothing outstanding");
                    err_count++;
                end else begin
                    want = expected_steps.pop_front();
                    check_field("accepted",     want.accepted,     o_result.accepted);
                    check_field("seq_state",    want.seq_state,    o_result.seq_state);
                    check_field("result_code",  want.result_code,  o_result.result_code);
                    check_field("result_event", want.result_event, o_result.result_event);
                    check_field("cmd_kind",     want.cmd_kind,     o_result.cmd_kind);
                    check_field("cmd_address",  want.cmd_address,  o_result.cmd_address);
                    check_field("cmd_value",    want.cmd_value,    o_result.cmd_value);
                end
            end
            if (i_valid && !o_stall) begin
                expected_steps.push_back(step_sequencer(i_item));
                ev_fired = 1'b1;
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("flash_program_erase_sequencer_top_tb: done, errors");
            $finish;
        end
    end

    function automatic void push_ev(t_in_item ev, bit hold);
        t_pending p;
        p.ev   = ev;
        p.hold = hold;
        event_q.push_back(p);
        queued_total++;
    endfunction

    function automatic t_in_item make_ev(t_action act, logic [2:0] op, logic [31:0] addr,
                                         logic [31:0] data, logic [15:0] opt,
                                         logic [1:0] status);
        t_in_item ev;
        ev.action         = act;
        ev.op_type        = op;
        ev.target_address = addr;
        ev.word_data      = data;
        ev.opt_value      = opt;
        ev.flash_status   = status;
        return ev;
    endfunction

    function automatic t_in_item rand_ev(t_action act);
        return make_ev(act, 3'($urandom_range(7)), $urandom, $urandom,
                       16'($urandom_range(16'hFFFF)), 2'($urandom_range(3)));
    endfunction

    task automatic write_timeout(t_cfg_idx idx, logic [TMO_WIDTH-1:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_ERASE_TMO)
            erase_tmo = val;
        else
            prog_tmo = val;
    endtask

    // Wait until every event is taken and every result is back, then let
    // the two-stage pipe empty.
    task automatic wait_quiet();
        while (event_q.size() != 0 || i_valid) @(posedge i_clk);
        while (expected_steps.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Mostly complete operations with random payload: clear, start, then a
    // run of ticks with mostly good status. Some cancels, stray starts and
    // pure noise mixed in.
    task automatic gen_random(int n);
        int       first;
        int       nticks;
        int       pick;
        bit       hold_done;
        bit       hold;
        t_in_item ev;
        first = queued_total;
        hold_done = 1'b0;
        while (queued_total - first < n) begin
            if ($urandom_range(99) < 85) begin
                if ($urandom_range(9) != 0)
                    push_ev(rand_ev(ACT_CLEAR), 1'b0);
                ev = rand_ev(ACT_START);
                if ($urandom_range(9) != 0)
                    ev.op_type[2] = 1'b0;
                // At least once per call, let the pipe run completely dry mid-stream.
                hold = (!hold_done && queued_total - first >= 20) || $urandom_range(49) == 0;
                hold_done |= hold;
                push_ev(ev, hold);
                nticks = $urandom_range(8, 20);
                repeat (nticks) begin
                    pick = $urandom_range(99);
                    if (pick < 3) begin
                        push_ev(rand_ev(ACT_CANCEL), 1'b0);
                    end else if (pick < 5) begin
                        push_ev(rand_ev(ACT_START), 1'b0);
                    end else begin
                        ev = rand_ev(ACT_TICK);
                        pick = $urandom_range(99);
                        if (pick < 70)
                            ev.flash_status = STAT_DONE;
                        else if (pick < 88)
                            ev.flash_status = STAT_BUSY;
                        else
                            ev.flash_status = $urandom_range(1) ? STAT_FAULT : STAT_FAULT_HI;
                        push_ev(ev, 1'b0);
                    end
                end
            end else begin
                repeat ($urandom_range(1, 6))
                    push_ev(rand_ev(t_action'($urandom_range(3))), 1'b0);
            end
        end
    endtask

    task automatic run_phase(int idle, int stall, logic [TMO_WIDTH-1:0] etmo,
                             logic [TMO_WIDTH-1:0] ptmo, int n);
        write_timeout(CFG_ERASE_TMO, etmo);
        write_timeout(CFG_PROG_TMO, ptmo);
        idle_pct  = idle;
        stall_pct = stall;
        gen_random(n);
        wait_quiet();
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed opening on reset timeouts, no idling.
        push_ev(make_ev(ACT_TICK,   3'b000, '0, '0, '0, STAT_DONE), 1'b0); // tick in idle
        push_ev(make_ev(ACT_CANCEL, 3'b000, '0, '0, '0, STAT_DONE), 1'b0); // cancel in idle
        // bad type while idle: latched, pending, still idle
        push_ev(make_ev(ACT_START, 3'b111, '1, '1, '1, STAT_FAULT_HI), 1'b0);
        push_ev(make_ev(ACT_START, 3'b100, '0, '0, '0, STAT_BUSY), 1'b0);
        push_ev(make_ev(ACT_CLEAR, 3'b000, '0, '0, '0, STAT_DONE), 1'b0);
        push_ev(make_ev(ACT_START, {1'b0, OP_WORD_PROG}, '1, '1, '0, STAT_DONE), 1'b0);
        // start while busy is dropped
        push_ev(make_ev(ACT_START, {1'b0, OP_OPT_ERASE}, '0, '0, '1, STAT_DONE), 1'b0);
        push_ev(make_ev(ACT_TICK, 3'b000, '0, '0, '0, STAT_DONE), 1'b0);   // init
        push_ev(make_ev(ACT_TICK, 3'b000, '0, '0, '0, STAT_DONE), 1'b0);   // unlock
        push_ev(make_ev(ACT_TICK, 3'b000, '0, '0, '0, STAT_DONE), 1'b0);   // clear flags
        push_ev(make_ev(ACT_TICK, 3'b000, '0, '0, '0, STAT_BUSY), 1'b0);   // wait, busy
        push_ev(make_ev(ACT_TICK, 3'b000, '0, '0, '0, STAT_DONE), 1'b0);   // wait, ready
        push_ev(make_ev(ACT_TICK, 3'b000, '0, '0, '0, STAT_DONE), 1'b0);   // set mode
        push_ev(make_ev(ACT_TICK, 3'b000, '0, '0, '0, STAT_DONE), 1'b0);   // write word
        push_ev(make_ev(ACT_TICK, 3'b000, '0, '0, '0, STAT_DONE), 1'b0);   // start
        push_ev(make_ev(ACT_TICK, 3'b000, '0, '0, '0, STAT_FAULT_HI), 1'b0); // fault
        push_ev(make_ev(ACT_TICK,   3'b000, '0, '0, '0, STAT_DONE), 1'b0); // tick in error
        push_ev(make_ev(ACT_CANCEL, 3'b000, '0, '0, '0, STAT_DONE), 1'b0); // cancel in error
        push_ev(make_ev(ACT_CLEAR,  3'b000, '0, '0, '0, STAT_DONE), 1'b0);
        push_ev(make_ev(ACT_START, {1'b0, OP_OPT_PROG}, '0, '0, 16'hFFFF, STAT_DONE), 1'b0);
        push_ev(make_ev(ACT_TICK, 3'b000, '0, '0, '0, STAT_DONE), 1'b0);
        push_ev(make_ev(ACT_TICK, 3'b000, '0, '0, '0, STAT_DONE), 1'b0);   // option unlock
        push_ev(make_ev(ACT_CANCEL, 3'b000, '0, '0, '0, STAT_DONE), 1'b0); // cancel: lock
        push_ev(make_ev(ACT_CLEAR,  3'b000, '0, '0, '0, STAT_DONE), 1'b0);
        push_ev(make_ev(ACT_START, {1'b0, OP_PAGE_ERASE}, '1, '0, '0, STAT_DONE), 1'b0);
        gen_random(350);
        wait_quiet();

        // Zero budget: any busy poll times out at once. Sender idles.
        run_phase(63, 0, '0, '0, 400);
        // Largest budget, receiver stalls.
        run_phase(0, 63, '1, '1, 400);
        // Tiny budgets so some polls run out, light idling on both sides.
        run_phase(13, 13, TMO_WIDTH'($urandom_range(1, 6)), TMO_WIDTH'($urandom_range(0, 3)),
                  400);
        // Back to full rate.
        run_phase(0, 0, TMO_WIDTH'(2), TMO_WIDTH'(1), 400);

        if (err_count == 0)
            $display("flash_program_erase_sequencer_top_tb: done, clean");
        else
            $display("flash_program_erase_sequencer_top_tb: done, errors");
        $finish;
    end

endmodule
